// File: src/fcel_pkg.sv
// ----------------------------------------------------------------------------
// fcel_pkg
// shared types, register map and constants of the fat cluster entry locator
// ----------------------------------------------------------------------------
package fcel_pkg;

  // fat type codes
  localparam logic [1:0] FAT_T12 = 2'd0;
  localparam logic [1:0] FAT_T16 = 2'd1;
  localparam logic [1:0] FAT_T32 = 2'd2;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_BPS  = 3'd0;
  localparam logic [2:0] REG_SPC  = 3'd1;
  localparam logic [2:0] REG_RES  = 3'd2;
  localparam logic [2:0] REG_COPY = 3'd3;
  localparam logic [2:0] REG_ROOT = 3'd4;
  localparam logic [2:0] REG_FSS  = 3'd5;
  localparam logic [2:0] REG_FSL  = 3'd6;
  localparam logic [2:0] REG_VOL  = 3'd7;

  // entry offset width and divider shape
  localparam int OFF_W        = 30;
  localparam int DIV_PER_STG  = 5;
  localparam int DIV_STAGES   = OFF_W / DIV_PER_STG;
  localparam int PIPE_LAT     = DIV_STAGES + 3;

  // cluster count limits
  localparam logic [16:0] LIM_T12 = 17'd4085;
  localparam logic [16:0] LIM_T16 = 17'd65525;

  // chain marks
  localparam logic [27:0] EOC12 = 28'h0000FF8;
  localparam logic [27:0] EOC16 = 28'h000FFF8;
  localparam logic [27:0] EOC32 = 28'hFFFFFF8;
  localparam logic [27:0] BAD12 = 28'h0000FF7;
  localparam logic [27:0] BAD16 = 28'h000FFF7;
  localparam logic [27:0] BAD32 = 28'hFFFFFF7;

  typedef struct packed {
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entry_count;
    logic [15:0] fat_sectors_short;
    logic [31:0] fat_sectors_long;
    logic [31:0] volume_sectors;
  } cfg_t;

  typedef struct packed {
    logic        ready;
    logic [31:0] fds;
    logic [1:0]  ftype;
  } geom_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic [27:0] next_cluster;
    logic        eoc;
    logic        bad;
    logic        free;
    logic        invalid;
    logic [1:0]  ftype;
    logic [1:0]  str;
    logic [31:0] dprod;
  } side_t;

endpackage

// File: src/fcel_geom.sv
// ----------------------------------------------------------------------------
// fcel_geom
// sequencer that derives first data sector and fat type from the geometry
// ----------------------------------------------------------------------------
module fcel_geom (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  fcel_pkg::cfg_t cfg,
  output fcel_pkg::geom_t geo
);
  import fcel_pkg::*;

  typedef enum logic [2:0] {G_LOAD, G_DIV, G_MUL, G_SUM, G_SUB, G_TYPE, G_DONE} gstate_t;

  gstate_t     state;
  logic [21:0] dvd;
  logic [15:0] rem;
  logic [21:0] quo;
  logic [4:0]  cnt;
  logic [39:0] prod;
  logic [24:0] lim12;
  logic [24:0] lim16;
  logic [40:0] fds;
  logic [31:0] dsecs;
  logic [1:0]  ftype;

  logic [15:0] bps_eff;
  logic [7:0]  spc_eff;
  logic [31:0] fat_size;
  logic [16:0] r17;
  logic        ge;

  always_comb begin
    bps_eff  = (cfg.bytes_per_sector == 16'd0) ? 16'd1 : cfg.bytes_per_sector;
    spc_eff  = (cfg.sectors_per_cluster == 8'd0) ? 8'd1 : cfg.sectors_per_cluster;
    fat_size = (cfg.fat_sectors_short != 16'd0) ? {16'd0, cfg.fat_sectors_short}
                                                : cfg.fat_sectors_long;
    r17      = {rem, dvd[21]};
    ge       = r17 >= {1'b0, bps_eff};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= G_LOAD;
    end else begin
      unique case (state)
        G_LOAD: begin
          // ceil(root entries * 32 / bytes per sector)
          dvd   <= {1'b0, cfg.root_entry_count, 5'd0} + {6'd0, bps_eff} - 22'd1;
          rem   <= 16'd0;
          quo   <= 22'd0;
          cnt   <= 5'd0;
          state <= G_DIV;
        end
        G_DIV: begin
          dvd <= {dvd[20:0], 1'b0};
          rem <= ge ? 16'(r17 - {1'b0, bps_eff}) : r17[15:0];
          quo <= {quo[20:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd21) begin
            state <= G_MUL;
          end
        end
        G_MUL: begin
          prod  <= cfg.fat_copies * fat_size;
          lim12 <= spc_eff * LIM_T12;
          lim16 <= spc_eff * LIM_T16;
          state <= G_SUM;
        end
        G_SUM: begin
          fds   <= {1'b0, prod} + {25'd0, cfg.reserved_sectors} + {19'd0, quo};
          state <= G_SUB;
        end
        G_SUB: begin
          dsecs <= ({9'd0, cfg.volume_sectors} >= fds) ? cfg.volume_sectors - fds[31:0]
                                                        : 32'd0;
          state <= G_TYPE;
        end
        G_TYPE: begin
          if (dsecs < {7'd0, lim12}) begin
            ftype <= FAT_T12;
          end else if (dsecs < {7'd0, lim16}) begin
            ftype <= FAT_T16;
          end else begin
            ftype <= FAT_T32;
          end
          state <= G_DONE;
        end
        G_DONE: begin
          state <= G_DONE;
        end
        default: begin
          state <= G_LOAD;
        end
      endcase
    end
  end

  assign geo.ready = (state == G_DONE);
  assign geo.fds   = fds[31:0];
  assign geo.ftype = ftype;

endmodule

// File: src/fcel_div.sv
// ----------------------------------------------------------------------------
// fcel_div
// pipelined restoring divider, several quotient bits per stage
// ----------------------------------------------------------------------------
module fcel_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [fcel_pkg::OFF_W-1:0] in_num,
  input  logic [15:0]               divisor,
  input  fcel_pkg::side_t           in_side,
  output logic                      out_valid,
  output logic [fcel_pkg::OFF_W-1:0] out_quot,
  output logic [15:0]               out_rem,
  output fcel_pkg::side_t           out_side
);
  import fcel_pkg::*;

  logic                vld  [DIV_STAGES+1];
  logic [OFF_W-1:0]    num  [DIV_STAGES+1];
  logic [OFF_W-1:0]    quot [DIV_STAGES+1];
  logic [15:0]         rem  [DIV_STAGES+1];
  side_t               side [DIV_STAGES+1];

  assign vld[0]  = in_valid;
  assign num[0]  = in_num;
  assign quot[0] = '0;
  assign rem[0]  = 16'd0;
  assign side[0] = in_side;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    logic [OFF_W-1:0] n_num;
    logic [OFF_W-1:0] n_quot;
    logic [15:0]      n_rem;
    logic [16:0]      r17;

    always_comb begin
      n_num  = num[k];
      n_quot = quot[k];
      n_rem  = rem[k];
      r17    = 17'd0;
      for (int i = 0; i < DIV_PER_STG; i++) begin
        r17   = {n_rem, n_num[OFF_W-1]};
        n_num = {n_num[OFF_W-2:0], 1'b0};
        if (r17 >= {1'b0, divisor}) begin
          n_rem  = 16'(r17 - {1'b0, divisor});
          n_quot = {n_quot[OFF_W-2:0], 1'b1};
        end else begin
          n_rem  = r17[15:0];
          n_quot = {n_quot[OFF_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      num[k+1]  <= n_num;
      quot[k+1] <= n_quot;
      rem[k+1]  <= n_rem;
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_quot  = quot[DIV_STAGES];
  assign out_rem   = rem[DIV_STAGES];
  assign out_side  = side[DIV_STAGES];

endmodule

// File: src/fat_cluster_entry_locator.sv
// ----------------------------------------------------------------------------
// fat_cluster_entry_locator
// locates a cluster's fat entry and data sector and decodes its fat word
// ----------------------------------------------------------------------------
//  channel   signals                                 direction
//  request   start, busy, cluster, raw_entry         in (busy out)
//  result    done, fat_sector .. cluster_invalid     out, one cycle strobe
//  config    psel penable pwrite paddr pwdata prdata in (prdata, pready out)
//
//  a request is taken on any edge with start high and busy low, one per cycle
//  each result passes through these registers in order: capture,
//  offset/decode, six divider stages (five quotient bits each), output add
//  after reset or any register write the geometry sequencer steps through
//  load, serial root size divide, multiply, sum, subtract and type with busy held high
//  the result side cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
module fat_cluster_entry_locator (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [27:0] cluster,
  input  logic [31:0] raw_entry,
  // result
  output logic        done,
  output logic [31:0] fat_sector,
  output logic [15:0] entry_offset,
  output logic [1:0]  sectors_to_read,
  output logic [31:0] data_sector,
  output logic [31:0] first_data_sector,
  output logic [1:0]  fat_type,
  output logic [27:0] next_cluster,
  output logic        end_of_chain,
  output logic        bad_cluster,
  output logic        free_cluster,
  output logic        cluster_invalid,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fcel_pkg::*;

  cfg_t  cfg;
  geom_t geo;
  logic  wr_en;
  logic  accept;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_sector    <= 16'd512;
      cfg.sectors_per_cluster <= 8'd1;
      cfg.reserved_sectors    <= 16'd1;
      cfg.fat_copies          <= 8'd2;
      cfg.root_entry_count    <= 16'd224;
      cfg.fat_sectors_short   <= 16'd9;
      cfg.fat_sectors_long    <= 32'd0;
      cfg.volume_sectors      <= 32'd2880;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_BPS:  cfg.bytes_per_sector    <= pwdata[15:0];
        REG_SPC:  cfg.sectors_per_cluster <= pwdata[7:0];
        REG_RES:  cfg.reserved_sectors    <= pwdata[15:0];
        REG_COPY: cfg.fat_copies          <= pwdata[7:0];
        REG_ROOT: cfg.root_entry_count    <= pwdata[15:0];
        REG_FSS:  cfg.fat_sectors_short   <= pwdata[15:0];
        REG_FSL:  cfg.fat_sectors_long    <= pwdata;
        REG_VOL:  cfg.volume_sectors      <= pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BPS:  prdata = {16'd0, cfg.bytes_per_sector};
      REG_SPC:  prdata = {24'd0, cfg.sectors_per_cluster};
      REG_RES:  prdata = {16'd0, cfg.reserved_sectors};
      REG_COPY: prdata = {24'd0, cfg.fat_copies};
      REG_ROOT: prdata = {16'd0, cfg.root_entry_count};
      REG_FSS:  prdata = {16'd0, cfg.fat_sectors_short};
      REG_FSL:  prdata = cfg.fat_sectors_long;
      REG_VOL:  prdata = cfg.volume_sectors;
      default:  prdata = 32'd0;
    endcase
  end

  // geometry derived once per configuration
  fcel_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .restart (wr_en),
    .cfg     (cfg),
    .geo     (geo)
  );

  assign busy   = !geo.ready;
  assign accept = start && !busy;

  // stage 0: capture request
  logic        v0;
  logic [27:0] n0;
  logic [31:0] raw0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    if (accept) begin
      n0   <= cluster;
      raw0 <= raw_entry;
    end
  end

  // stage 1: entry offset, word decode, cluster minus two times sectors per cluster
  logic [15:0]      bps_eff;
  logic [7:0]       spc_eff;
  logic [OFF_W-1:0] off_c;
  logic [27:0]      next_c;
  logic [27:0]      eoc_mark;
  logic [27:0]      bad_mark;
  logic [31:0]      nm2;
  logic [39:0]      prod_c;
  side_t            side_c;

  assign bps_eff = (cfg.bytes_per_sector == 16'd0) ? 16'd1 : cfg.bytes_per_sector;
  assign spc_eff = (cfg.sectors_per_cluster == 8'd0) ? 8'd1 : cfg.sectors_per_cluster;

  always_comb begin
    unique case (geo.ftype)
      FAT_T12: begin
        // 1.5 bytes per entry, the word holds a nibble of the neighbor
        off_c    = {2'd0, n0} + {3'd0, n0[27:1]};
        next_c   = n0[0] ? {16'd0, raw0[15:4]} : {16'd0, raw0[11:0]};
        eoc_mark = EOC12;
        bad_mark = BAD12;
      end
      FAT_T16: begin
        off_c    = {1'b0, n0, 1'b0};
        next_c   = {12'd0, raw0[15:0]};
        eoc_mark = EOC16;
        bad_mark = BAD16;
      end
      default: begin
        off_c    = {n0, 2'b00};
        next_c   = raw0[27:0];
        eoc_mark = EOC32;
        bad_mark = BAD32;
      end
    endcase
    nm2 = {4'd0, n0} - 32'd2;
  end

  logic             v1;
  logic [OFF_W-1:0] off1;
  side_t            side1;

  assign prod_c = nm2 * spc_eff;

  always_comb begin
    side_c.next_cluster = next_c;
    side_c.eoc          = next_c >= eoc_mark;
    side_c.bad          = next_c == bad_mark;
    side_c.free         = next_c == 28'd0;
    side_c.invalid      = n0 < 28'd2;
    side_c.ftype        = geo.ftype;
    side_c.str          = (geo.ftype == FAT_T12) ? 2'd2 : 2'd1;
    side_c.dprod        = prod_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    off1  <= off_c;
    side1 <= side_c;
  end

  // divider stages: offset over bytes per sector
  logic             dv;
  logic [OFF_W-1:0] dq;
  logic [15:0]      dr;
  side_t            ds;

  fcel_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_num    (off1),
    .divisor   (bps_eff),
    .in_side   (side1),
    .out_valid (dv),
    .out_quot  (dq),
    .out_rem   (dr),
    .out_side  (ds)
  );

  // output register: final adds
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv;
    end
    fat_sector        <= {16'd0, cfg.reserved_sectors} + {{(32-OFF_W){1'b0}}, dq};
    entry_offset      <= dr;
    sectors_to_read   <= ds.str;
    data_sector       <= ds.dprod + geo.fds;
    first_data_sector <= geo.fds;
    fat_type          <= ds.ftype;
    next_cluster      <= ds.next_cluster;
    end_of_chain      <= ds.eoc;
    bad_cluster       <= ds.bad;
    free_cluster      <= ds.free;
    cluster_invalid   <= ds.invalid;
  end

  // a register write restarts the geometry sequencer
  a_wr_busy: assert property (@(posedge clk) disable iff (rst) wr_en |=> busy)
    else $error("busy not raised after register write");

  // every accepted request yields one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("result missing after request");

  // two-sector reads only on fat12
  a_str: assert property (@(posedge clk) disable iff (rst)
    done |-> ((sectors_to_read == 2'd2) == (fat_type == FAT_T12)))
    else $error("sector count does not match fat type");

  // a free entry is neither end of chain nor bad
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done && free_cluster |-> !end_of_chain && !bad_cluster)
    else $error("conflicting entry flags");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fat cluster entry locator: directed and random
// cluster lookups over several volume geometries, checked against a predictor
// ----------------------------------------------------------------------------

module tb_top;
  import fcel_pkg::*;

  typedef struct packed {
    logic [31:0] fat_sector;
    logic [15:0] entry_offset;
    logic [1:0]  sectors_to_read;
    logic [31:0] data_sector;
    logic [31:0] first_data_sector;
    logic [1:0]  fat_type;
    logic [27:0] next_cluster;
    logic        end_of_chain;
    logic        bad_cluster;
    logic        free_cluster;
    logic        cluster_invalid;
  } lookup_t;

  class lookup_board;
    lookup_t pending[$];
    int errors;
    int checked;
    // geometry copy
    logic [15:0] bps, res, root, fss;
    logic [7:0]  spc, copies;
    logic [31:0] fsl, vol;

    function void reset_geom();
      bps = 512; spc = 1; res = 1; copies = 2;
      root = 224; fss = 9; fsl = 0; vol = 2880;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_BPS:  bps = v[15:0];
        REG_SPC:  spc = v[7:0];
        REG_RES:  res = v[15:0];
        REG_COPY: copies = v[7:0];
        REG_ROOT: root = v[15:0];
        REG_FSS:  fss = v[15:0];
        REG_FSL:  fsl = v;
        default:  vol = v;
      endcase
    endfunction

    // work out the lookup for one accepted request
    function void note_request(logic [27:0] n, logic [31:0] raw);
      lookup_t r;
      logic [63:0] dv, sp, fsize, rsecs, fds, dsecs, cnt, off, nxt, eoc, bad;
      dv = (bps == 0) ? 64'd1 : 64'(bps);
      sp = (spc == 0) ? 64'd1 : 64'(spc);
      fsize = (fss != 0) ? 64'(fss) : 64'(fsl);
      rsecs = (64'(root) * 32 + dv - 1) / dv;
      fds = 64'(res) + 64'(copies) * fsize + rsecs;
      dsecs = (64'(vol) >= fds) ? 64'(vol) - fds : 64'd0;
      cnt = dsecs / sp;
      if (cnt < 4085) begin
        r.fat_type = FAT_T12;
        off = 64'(n) + 64'(n >> 1);
        nxt = n[0] ? 64'(raw[15:4]) : 64'(raw[11:0]);
        eoc = EOC12; bad = BAD12;
      end else if (cnt < 65525) begin
        r.fat_type = FAT_T16;
        off = 64'(n) * 2;
        nxt = 64'(raw[15:0]);
        eoc = EOC16; bad = BAD16;
      end else begin
        r.fat_type = FAT_T32;
        off = 64'(n) * 4;
        nxt = 64'(raw[27:0]);
        eoc = EOC32; bad = BAD32;
      end
      r.fat_sector = 32'(64'(res) + off / dv);
      r.entry_offset = 16'(off % dv);
      r.sectors_to_read = (r.fat_type == FAT_T12) ? 2'd2 : 2'd1;
      r.data_sector = (32'(n) - 32'd2) * 32'(sp) + fds[31:0];
      r.first_data_sector = fds[31:0];
      r.next_cluster = nxt[27:0];
      r.end_of_chain = nxt >= eoc;
      r.bad_cluster = nxt == bad;
      r.free_cluster = nxt == 0;
      r.cluster_invalid = n < 2;
      pending.push_back(r);
    endfunction

    function void check_result(lookup_t a);
      lookup_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e !== a) begin
        errors++;
        $display("%0t: mismatch exp fs=%h off=%h str=%0d ds=%h fds=%h t=%0d nx=%h e/b/f/i=%b%b%b%b",
                 $time, e.fat_sector, e.entry_offset, e.sectors_to_read, e.data_sector,
                 e.first_data_sector, e.fat_type, e.next_cluster, e.end_of_chain,
                 e.bad_cluster, e.free_cluster, e.cluster_invalid);
        $display("%0t:          got fs=%h off=%h str=%0d ds=%h fds=%h t=%0d nx=%h e/b/f/i=%b%b%b%b",
                 $time, a.fat_sector, a.entry_offset, a.sectors_to_read, a.data_sector,
                 a.first_data_sector, a.fat_type, a.next_cluster, a.end_of_chain,
                 a.bad_cluster, a.free_cluster, a.cluster_invalid);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        start, busy;
  logic [27:0] cluster;
  logic [31:0] raw_entry;
  logic        done;
  lookup_t     res_now;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  lookup_board board;
  int          idle_pct;
  int          requests;
  longint      cycles;

  fat_cluster_entry_locator dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cluster(cluster), .raw_entry(raw_entry),
    .done(done),
    .fat_sector(res_now.fat_sector), .entry_offset(res_now.entry_offset),
    .sectors_to_read(res_now.sectors_to_read), .data_sector(res_now.data_sector),
    .first_data_sector(res_now.first_data_sector), .fat_type(res_now.fat_type),
    .next_cluster(res_now.next_cluster), .end_of_chain(res_now.end_of_chain),
    .bad_cluster(res_now.bad_cluster), .free_cluster(res_now.free_cluster),
    .cluster_invalid(res_now.cluster_invalid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // result sampling; the receiver has no way to stall
  always @(posedge clk) begin
    if (!rst && done) board.check_result(res_now);
  end

  // cycle limit: ~1040 requests, geometry reruns and drains included
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[fat_cluster_entry_locator] ERROR");
      $finish;
    end
  end

  // apb write: setup then access, pready is tied high
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    board.write_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one request; start stays high back to back when no idle is drawn
  task automatic send(logic [27:0] n, logic [31:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1; cluster <= n; raw_entry <= raw;
    do @(posedge clk); while (busy);
    board.note_request(n, raw);
    requests++;
    @(negedge clk);
  endtask

  // drain, then let the pipeline settle before any register change
  task automatic drain();
    int k;
    start <= 0;
    k = 0;
    while (board.pending.size() != 0 && k < 2000) begin
      @(negedge clk);
      k++;
    end
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic set_geom(logic [15:0] b, logic [7:0] s, logic [15:0] r, logic [7:0] c,
                          logic [15:0] ro, logic [15:0] fs, logic [31:0] fl,
                          logic [31:0] v);
    write_reg(REG_BPS, {16'(0), b});
    write_reg(REG_SPC, {24'(0), s});
    write_reg(REG_RES, {16'(0), r});
    write_reg(REG_COPY, {24'(0), c});
    write_reg(REG_ROOT, {16'(0), ro});
    write_reg(REG_FSS, {16'(0), fs});
    write_reg(REG_FSL, fl);
    write_reg(REG_VOL, v);
  endtask

  // cluster small (up to 7 or up to 70000) half the time, else any 28-bit value
  function automatic logic [27:0] pick_cluster();
    case ($urandom_range(3))
      0: return 28'($urandom_range(7));
      1: return 28'($urandom_range(70000));
      default: return 28'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_raw();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: return 32'h0;
      1: return {w[31:28], 28'hFFFFFF7};
      2: return {w[31:16], 16'hFFF7};
      3: return {w[31:16], 16'hFF7F};
      default: return w;
    endcase
  endfunction

  task automatic random_phase(int count);
    repeat (count) send(pick_cluster(), pick_raw());
  endtask

  initial begin
    board = new();
    board.reset_geom();
    rst = 1; start = 0; cluster = 0; raw_entry = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    idle_pct = 0; requests = 0; cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed lookups on the reset floppy geometry (fat12): extremes, odd/even
    // clusters, invalid clusters below two, free/bad/end marks
    send(28'd0, 32'h0);
    send(28'd1, 32'hFFFFFFFF);
    send(28'd2, 32'h00000FF8);
    send(28'd3, 32'h0000FF70);
    send(28'd4, 32'h00000FF7);
    send(28'd5, 32'h0000FFF0);
    send(28'hFFFFFFF, 32'hFFFFFFFF);
    send(28'd340, 32'h12345678);
    drain();

    // fat16 volume
    set_geom(16'd512, 8'd4, 16'd4, 8'd2, 16'd512, 16'd200, 32'd0, 32'd200000);
    send(28'd2, 32'h0000FFF7);
    send(28'd3, 32'h0000FFF8);
    send(28'd255, 32'hABCD0000);
    send(28'hFFFFFFF, 32'h5555AAAA);
    drain();

    // fat32 volume with long fat size and zero root entries
    set_geom(16'd4096, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0, 32'd8000, 32'hFFFFFFFF);
    send(28'd2, 32'hFFFFFFF7);
    send(28'd9, 32'h0FFFFFF8);
    send(28'd1, 32'hF0000000);
    send(28'hFFFFFFF, 32'hFFFFFFFF);
    drain();

    // zero divisor and zero sectors per cluster, short volume saturating to
    // fat12, first data sector overflowing; wide geometry overflowing the data sector
    set_geom(16'd0, 8'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0, 32'hFFFFFFFF, 32'd0);
    send(28'd7, 32'h0000FFF8);
    send(28'hFFFFFFF, 32'h0);
    send(28'd0, 32'h12345678);
    drain();
    set_geom(16'hFFFF, 8'hFF, 16'd0, 8'd1, 16'd0, 16'hFFFF, 32'd0, 32'hFFFFFFFF);
    send(28'd3, 32'hFFFFFFFF);
    send(28'h8000001, 32'h0000FFF7);
    drain();

    // random phases, sender idle pattern changes between them
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph % 3 == 0) ? 30 : (ph % 3 == 1) ? 66 : 0;
      if (ph % 4 == 3)
        set_geom(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                 16'($urandom), ($urandom_range(1) ? 16'($urandom) : 16'd0),
                 $urandom, $urandom);
      else
        set_geom(16'(1 << $urandom_range(12, 9)), 8'(1 << $urandom_range(6)),
                 16'($urandom_range(64)), 8'($urandom_range(1, 2)),
                 16'($urandom_range(1) ? 512 : 0),
                 ($urandom_range(1) ? 16'($urandom_range(500)) : 16'd0),
                 32'($urandom_range(40000)),
                 (ph % 4 == 0) ? 32'($urandom_range(20000)) :
                 (ph % 4 == 1) ? 32'($urandom_range(2000000)) : $urandom);
      random_phase(85);
      drain();
    end

    $display("ran %0d lookups over fat12/16/32 geometries, zero divisors and", requests);
    $display("saturating volumes; %0d results checked", board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[fat_cluster_entry_locator] OK");
    else
      $display("[fat_cluster_entry_locator] ERROR");
    $finish;
  end
endmodule

// File: filelist.f
src/fcel_pkg.sv
src/fcel_geom.sv
src/fcel_div.sv
src/fat_cluster_entry_locator.sv
tb/tb_top.sv
